[rtl/websocket_frame_deframer_macros.svh]
// ----------------------------------------------------------------------------
// websocket_frame_deframer assertion macros
// Shared concurrent assertion forms; expect clk and rst in scope.
// ----------------------------------------------------------------------------
`ifndef WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH
`define WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH

// same-cycle implication
`define WSD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// next-cycle implication
`define WSD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

[rtl/wsd_pkg.sv]
// ----------------------------------------------------------------------------
// wsd_pkg
// Types and constants shared by the WebSocket deframer modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wsd_pkg;

  typedef enum logic [2:0] {
    PH_HDR0   = 3'd0,
    PH_HDR1   = 3'd1,
    PH_EXTLEN = 3'd2,
    PH_KEY    = 3'd3,
    PH_DATA   = 3'd4,
    PH_HALT   = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    EV_BYTE  = 3'd0,
    EV_END   = 3'd1,
    EV_CLOSE = 3'd2,
    EV_PONG  = 3'd3,
    EV_ERROR = 3'd4
  } ev_kind_t;

  typedef struct packed {
    ev_kind_t   kind;
    logic [7:0] data;
    logic       last;
    logic [3:0] mtype;
  } ev_t;

  localparam logic [3:0] OP_CONT  = 4'd0;
  localparam logic [3:0] OP_TEXT  = 4'd1;
  localparam logic [3:0] OP_BIN   = 4'd2;
  localparam logic [3:0] OP_CLOSE = 4'd8;
  localparam logic [3:0] OP_PING  = 4'd9;
  localparam logic [3:0] OP_PONG  = 4'd10;

  localparam logic [6:0] LEN16_CODE = 7'd126;
  localparam logic [6:0] LEN64_CODE = 7'd127;

  localparam logic [31:0] MAX_MSG_RESET = 32'd33554432;

  localparam logic CFG_MAX_MSG = 1'b0;
  localparam logic CFG_CLIENT  = 1'b1;

endpackage

[rtl/wsd_parser.sv]
// ----------------------------------------------------------------------------
// wsd_parser
// Front end: accepts stream bytes, walks the frame header, unmasks payload
// and classifies each byte into at most one event for the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "websocket_frame_deframer_macros.svh"

module wsd_parser (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  input  logic         in_stall,
  input  logic [7:0]   rx_byte,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [31:0]  cfg_data,
  output logic         ev_valid,
  output wsd_pkg::ev_t ev
);
  import wsd_pkg::*;

  logic [31:0] max_message_bytes;
  logic        client_side;

  phase_t      phase, phase_next;
  logic        frame_final, frame_final_next;
  logic        frame_masked, frame_masked_next;
  logic [3:0]  frame_opcode, frame_opcode_next;
  logic [3:0]  len_left, len_left_next;
  logic [63:0] frame_remaining, frame_remaining_next;
  logic [31:0] mask_key, mask_key_next;
  logic [1:0]  key_pos, key_pos_next;
  logic [3:0]  latched_type, latched_type_next;
  logic [31:0] msg_len, msg_len_next;

  logic        accept;
  logic        masked_bit;
  logic [6:0]  len7;
  logic        op_data;
  logic        short_len;
  logic [3:0]  lt_hdr;
  logic [3:0]  lt_v;
  logic        mask_v;
  logic [63:0] rem_v;
  logic [31:0] room;
  logic        hd_fail;
  logic        rem_zero;
  logic        key_zero;
  logic [63:0] rem_dec;
  logic [7:0]  key_byte;

  assign accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_message_bytes <= MAX_MSG_RESET;
      client_side       <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAX_MSG: max_message_bytes <= cfg_data;
        CFG_CLIENT:  client_side       <= cfg_data[0];
        default:     ;
      endcase
    end
  end

  // shared header decode and length checks
  always_comb begin
    masked_bit = rx_byte[7];
    len7       = rx_byte[6:0];
    op_data    = (frame_opcode == OP_CONT) || (frame_opcode == OP_TEXT) ||
                 (frame_opcode == OP_BIN);
    short_len  = (len7 != LEN16_CODE) && (len7 != LEN64_CODE);
    lt_hdr     = ((frame_opcode != OP_CONT) && (latched_type == 4'd0)) ?
                 frame_opcode : latched_type;
    if (phase == PH_HDR1) begin
      rem_v  = {57'd0, len7};
      mask_v = masked_bit;
      lt_v   = lt_hdr;
    end else begin
      rem_v  = {frame_remaining[55:0], rx_byte};
      mask_v = frame_masked;
      lt_v   = latched_type;
    end
    room     = max_message_bytes - msg_len;
    hd_fail  = (msg_len >= max_message_bytes) || (rem_v[63:32] != 32'd0) ||
               (rem_v[31:0] >= room);
    rem_zero = (rem_v == 64'd0);
    key_zero = (frame_remaining == 64'd0);
    rem_dec  = frame_remaining - 64'd1;
    unique case (key_pos)
      2'd0: key_byte = mask_key[31:24];
      2'd1: key_byte = mask_key[23:16];
      2'd2: key_byte = mask_key[15:8];
      2'd3: key_byte = mask_key[7:0];
      default: key_byte = 8'd0;
    endcase
  end

  // next state
  always_comb begin
    phase_next           = phase;
    frame_final_next     = frame_final;
    frame_masked_next    = frame_masked;
    frame_opcode_next    = frame_opcode;
    len_left_next        = len_left;
    frame_remaining_next = frame_remaining;
    mask_key_next        = mask_key;
    key_pos_next         = key_pos;
    latched_type_next    = latched_type;
    msg_len_next         = msg_len;
    if (accept) begin
      unique case (phase)
        PH_HDR0: begin
          frame_final_next  = rx_byte[7];
          frame_opcode_next = rx_byte[3:0];
          phase_next        = PH_HDR1;
        end
        PH_HDR1: begin
          priority if (frame_opcode == OP_PING || frame_opcode == OP_PONG) begin
            phase_next = PH_HDR0;
          end else if (frame_opcode == OP_CLOSE) begin
            phase_next        = PH_HDR0;
            latched_type_next = 4'd0;
            msg_len_next      = 32'd0;
          end else if (!op_data || (!client_side && !masked_bit)) begin
            phase_next = PH_HALT;
          end else if (!short_len) begin
            frame_masked_next    = masked_bit;
            latched_type_next    = lt_hdr;
            frame_remaining_next = 64'd0;
            len_left_next        = (len7 == LEN16_CODE) ? 4'd2 : 4'd8;
            phase_next           = PH_EXTLEN;
          end else begin
            frame_masked_next    = masked_bit;
            latched_type_next    = lt_hdr;
            frame_remaining_next = rem_v;
            if (hd_fail) begin
              phase_next = PH_HALT;
            end else begin
              msg_len_next = msg_len + rem_v[31:0];
              key_pos_next = 2'd0;
              if (mask_v) begin
                phase_next    = PH_KEY;
                mask_key_next = 32'd0;
              end else if (rem_zero) begin
                phase_next = PH_HDR0;
                if (frame_final) begin
                  latched_type_next = 4'd0;
                  msg_len_next      = 32'd0;
                end
              end else begin
                phase_next = PH_DATA;
              end
            end
          end
        end
        PH_EXTLEN: begin
          frame_remaining_next = rem_v;
          len_left_next        = len_left - 4'd1;
          if (len_left == 4'd1) begin
            if (hd_fail) begin
              phase_next = PH_HALT;
            end else begin
              msg_len_next = msg_len + rem_v[31:0];
              key_pos_next = 2'd0;
              if (mask_v) begin
                phase_next    = PH_KEY;
                mask_key_next = 32'd0;
              end else if (rem_zero) begin
                phase_next = PH_HDR0;
                if (frame_final) begin
                  latched_type_next = 4'd0;
                  msg_len_next      = 32'd0;
                end
              end else begin
                phase_next = PH_DATA;
              end
            end
          end
        end
        PH_KEY: begin
          mask_key_next = {mask_key[23:0], rx_byte};
          if (key_pos == 2'd3) begin
            key_pos_next = 2'd0;
            if (key_zero) begin
              phase_next = PH_HDR0;
              if (frame_final) begin
                latched_type_next = 4'd0;
                msg_len_next      = 32'd0;
              end
            end else begin
              phase_next = PH_DATA;
            end
          end else begin
            key_pos_next = key_pos + 2'd1;
          end
        end
        PH_DATA: begin
          key_pos_next         = key_pos + 2'd1;
          frame_remaining_next = rem_dec;
          if (rem_dec == 64'd0) begin
            phase_next = PH_HDR0;
            if (frame_final) begin
              latched_type_next = 4'd0;
              msg_len_next      = 32'd0;
            end
          end
        end
        PH_HALT: ;
        default: ;
      endcase
    end
  end

  // event output
  always_comb begin
    ev_valid = 1'b0;
    ev       = '{kind: EV_BYTE, data: 8'd0, last: 1'b0, mtype: 4'd0};
    if (accept) begin
      unique case (phase)
        PH_HDR1: begin
          priority if (frame_opcode == OP_PING) begin
            ev_valid = 1'b1;
            ev.kind  = EV_PONG;
          end else if (frame_opcode == OP_PONG) begin
            ev_valid = 1'b0;
          end else if (frame_opcode == OP_CLOSE) begin
            ev_valid = 1'b1;
            ev.kind  = EV_CLOSE;
          end else if (!op_data || (!client_side && !masked_bit)) begin
            ev_valid = 1'b1;
            ev.kind  = EV_ERROR;
          end else if (short_len) begin
            if (hd_fail) begin
              ev_valid = 1'b1;
              ev.kind  = EV_ERROR;
            end else if (!mask_v && rem_zero && frame_final) begin
              ev_valid = 1'b1;
              ev.kind  = EV_END;
              ev.mtype = lt_v;
            end
          end
        end
        PH_EXTLEN: begin
          if (len_left == 4'd1) begin
            if (hd_fail) begin
              ev_valid = 1'b1;
              ev.kind  = EV_ERROR;
            end else if (!mask_v && rem_zero && frame_final) begin
              ev_valid = 1'b1;
              ev.kind  = EV_END;
              ev.mtype = lt_v;
            end
          end
        end
        PH_KEY: begin
          if (key_pos == 2'd3 && key_zero && frame_final) begin
            ev_valid = 1'b1;
            ev.kind  = EV_END;
            ev.mtype = latched_type;
          end
        end
        PH_DATA: begin
          ev_valid = 1'b1;
          ev.kind  = EV_BYTE;
          ev.data  = rx_byte ^ (frame_masked ? key_byte : 8'd0);
          ev.last  = (rem_dec == 64'd0) && frame_final;
          ev.mtype = latched_type;
        end
        PH_HDR0, PH_HALT: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HDR0;
      frame_final     <= 1'b0;
      frame_masked    <= 1'b0;
      frame_opcode    <= 4'd0;
      len_left        <= 4'd0;
      frame_remaining <= 64'd0;
      mask_key        <= 32'd0;
      key_pos         <= 2'd0;
      latched_type    <= 4'd0;
      msg_len         <= 32'd0;
    end else begin
      phase           <= phase_next;
      frame_final     <= frame_final_next;
      frame_masked    <= frame_masked_next;
      frame_opcode    <= frame_opcode_next;
      len_left        <= len_left_next;
      frame_remaining <= frame_remaining_next;
      mask_key        <= mask_key_next;
      key_pos         <= key_pos_next;
      latched_type    <= latched_type_next;
      msg_len         <= msg_len_next;
    end
  end

  `WSD_ASSERT_NXT(a_error_halts, ev_valid && ev.kind == EV_ERROR, phase == PH_HALT)
  `WSD_ASSERT_NXT(a_halt_sticks, phase == PH_HALT, phase == PH_HALT)
  `WSD_ASSERT_IMP(a_halt_silent, phase == PH_HALT, !ev_valid)
  `WSD_ASSERT_IMP(a_event_needs_byte, ev_valid, accept)

endmodule

[rtl/wsd_queue.sv]
// ----------------------------------------------------------------------------
// wsd_queue
// Short event queue between the parser and the output stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wsd_queue #(
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  wsd_pkg::ev_t push_ev,
  input  logic         pop,
  output wsd_pkg::ev_t head_ev,
  output logic         full,
  output logic         empty
);
  import wsd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  ev_t              slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, wr_ptr_next;
  logic [PTR_W-1:0] rd_ptr, rd_ptr_next;
  logic [CNT_W-1:0] count, count_next;
  logic             do_push, do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == CNT_W'(0));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head_ev = slots[rd_ptr];

  always_comb begin
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    count_next  = count;
    if (do_push) begin
      wr_ptr_next = (wr_ptr == PTR_W'(DEPTH - 1)) ? PTR_W'(0) : wr_ptr + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_next = (rd_ptr == PTR_W'(DEPTH - 1)) ? PTR_W'(0) : rd_ptr + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_next = count + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_ev;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

endmodule

[rtl/wsd_emitter.sv]
// ----------------------------------------------------------------------------
// wsd_emitter
// Back end: takes events off the queue and holds them on the result channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wsd_emitter (
  input  logic         clk,
  input  logic         rst,
  input  wsd_pkg::ev_t head_ev,
  input  logic         empty,
  output logic         pop,
  output logic         out_valid,
  input  logic         out_stall,
  output logic [2:0]   event_kind,
  output logic [7:0]   payload_byte,
  output logic         message_last,
  output logic [3:0]   message_type
);
  import wsd_pkg::*;

  ev_t  hold;
  logic out_valid_next;

  // load when the register is free or its event transfers this cycle
  assign pop = !empty && (!out_valid || !out_stall);

  always_comb begin
    if (pop) begin
      out_valid_next = 1'b1;
    end else if (out_valid && out_stall) begin
      out_valid_next = 1'b1;
    end else begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      hold <= head_ev;
    end
  end

  assign event_kind   = hold.kind;
  assign payload_byte = hold.data;
  assign message_last = hold.last;
  assign message_type = hold.mtype;

endmodule

[rtl/websocket_frame_deframer.sv]
// Each accepted byte's result is written into the event queue, then into the output hold register.
// Throughput: one byte per cycle unless stalled; non-payload bytes give at most a pong, close, end or error.
// Input stalls only while the event queue is full: QUEUE_DEPTH events waiting behind
// a stalled output result. Reset (synchronous, rst high) returns to the first header
// byte, clears any halt and the queue, and restores max_message_bytes and client_side.
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// Receive-side frame parser: header decode, unmasking and message tracking.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module websocket_frame_deframer #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  event_kind,
  output logic [7:0]  payload_byte,
  output logic        message_last,
  output logic [3:0]  message_type,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);
  import wsd_pkg::*;

  logic ev_valid;
  ev_t  ev;
  ev_t  head_ev;
  logic q_full;
  logic q_empty;
  logic pop;

  assign in_stall = q_full;

  wsd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .rx_byte   (rx_byte),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ev_valid  (ev_valid),
    .ev        (ev)
  );

  wsd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (ev_valid),
    .push_ev (ev),
    .pop     (pop),
    .head_ev (head_ev),
    .full    (q_full),
    .empty   (q_empty)
  );

  wsd_emitter u_emitter (
    .clk          (clk),
    .rst          (rst),
    .head_ev      (head_ev),
    .empty        (q_empty),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .event_kind   (event_kind),
    .payload_byte (payload_byte),
    .message_last (message_last),
    .message_type (message_type)
  );

endmodule

[dv/websocket_frame_deframer_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// websocket_frame_deframer_test
// Feeds WebSocket frame streams byte by byte through the deframer: control
// frames, fragmented messages, extended lengths, masked and unmasked payloads,
// length limits and a terminal error. A cycle-free parser inside the bench
// predicts every event, and each delivered event is checked against it. Both
// sides idle and stall at random.
// ----------------------------------------------------------------------------

module websocket_frame_deframer_test;
  import wsd_pkg::*;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  event_kind;
  logic [7:0]  payload_byte;
  logic        message_last;
  logic [3:0]  message_type;
  logic        cfg_we = 1'b0;
  logic        cfg_index = CFG_MAX_MSG;
  logic [31:0] cfg_data = 32'd0;

  websocket_frame_deframer dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .event_kind   (event_kind),
    .payload_byte (payload_byte),
    .message_last (message_last),
    .message_type (message_type),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // Parser state mirrored by the bench
  phase_t      ph = PH_HDR0;
  logic        frame_fin = 1'b0;
  logic        frame_mask = 1'b0;
  logic [3:0]  frame_op = OP_CONT;
  logic [3:0]  ext_left = 4'd0;
  logic [63:0] remaining = 64'd0;
  logic [31:0] rx_key = 32'd0;
  logic [1:0]  key_idx = 2'd0;
  logic [3:0]  msg_type = OP_CONT;
  logic [31:0] msg_len = 32'd0;
  logic [31:0] max_bytes = MAX_MSG_RESET;
  logic        client_mode = 1'b0;

  ev_t         pending_events[$];
  ev_t         want;
  int unsigned mismatches = 0;
  int unsigned bytes_sent = 0;
  int unsigned kind_count [8];
  logic        burst = 1'b0;
  logic        msg_open = 1'b0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #6_000_000;
    $display("timeout with %0d events still pending", pending_events.size());
    $display("TEST FAILED");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void queue_event(ev_kind_t kind, logic [7:0] data, logic last,
                                      logic [3:0] mtype);
    pending_events.push_back('{kind, data, last, mtype});
  endfunction

  function automatic void raise_error();
    ph = PH_HALT;
    queue_event(EV_ERROR, 8'h00, 1'b0, 4'd0);
  endfunction

  function automatic void body_start();
    key_idx = 2'd0;
    if (remaining == 64'd0) begin
      ph = PH_HDR0;
      if (frame_fin) begin
        queue_event(EV_END, 8'h00, 1'b0, msg_type);
        msg_type = OP_CONT;
        msg_len = 32'd0;
      end
    end else begin
      ph = PH_DATA;
    end
  endfunction

  function automatic void header_done();
    if (msg_len >= max_bytes || remaining >= {32'd0, max_bytes - msg_len}) begin
      raise_error();
    end else begin
      msg_len = msg_len + remaining[31:0];
      if (frame_mask) begin
        ph = PH_KEY;
        key_idx = 2'd0;
        rx_key = 32'd0;
      end else begin
        body_start();
      end
    end
  endfunction

  function automatic void deframe_byte(logic [7:0] b);
    logic [7:0] kb;
    logic [3:0] t;
    case (ph)
      PH_HDR0: begin
        frame_fin = b[7];
        frame_op = b[3:0];
        ph = PH_HDR1;
      end
      PH_HDR1: begin
        if (frame_op == OP_PING) begin
          ph = PH_HDR0;
          queue_event(EV_PONG, 8'h00, 1'b0, 4'd0);
        end else if (frame_op == OP_PONG) begin
          ph = PH_HDR0;
        end else if (frame_op == OP_CLOSE) begin
          ph = PH_HDR0;
          msg_type = OP_CONT;
          msg_len = 32'd0;
          queue_event(EV_CLOSE, 8'h00, 1'b0, 4'd0);
        end else if (frame_op > OP_BIN) begin
          raise_error();
        end else if (!client_mode && !b[7]) begin
          raise_error();
        end else begin
          frame_mask = b[7];
          if (frame_op != OP_CONT && msg_type == OP_CONT) msg_type = frame_op;
          remaining = 64'd0;
          if (b[6:0] == LEN16_CODE) begin
            ext_left = 4'd2;
            ph = PH_EXTLEN;
          end else if (b[6:0] == LEN64_CODE) begin
            ext_left = 4'd8;
            ph = PH_EXTLEN;
          end else begin
            remaining = {57'd0, b[6:0]};
            header_done();
          end
        end
      end
      PH_EXTLEN: begin
        remaining = {remaining[55:0], b};
        ext_left = ext_left - 4'd1;
        if (ext_left == 4'd0) header_done();
      end
      PH_KEY: begin
        rx_key = {rx_key[23:0], b};
        if (key_idx == 2'd3) body_start();
        else key_idx = key_idx + 2'd1;
      end
      PH_DATA: begin
        kb = frame_mask ? rx_key[8 * (3 - key_idx) +: 8] : 8'h00;
        t = msg_type;
        key_idx = key_idx + 2'd1;
        remaining = remaining - 64'd1;
        if (remaining == 64'd0) begin
          ph = PH_HDR0;
          if (frame_fin) begin
            msg_type = OP_CONT;
            msg_len = 32'd0;
          end
        end
        queue_event(EV_BYTE, b ^ kb, remaining == 64'd0 && frame_fin, t);
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------- checking

  function automatic void note_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $time, msg);
  endfunction

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && !out_stall) begin
      kind_count[event_kind]++;
      if (pending_events.size() == 0) begin
        note_mismatch($sformatf("unexpected event: kind %0d byte %02h last %0b type %0d",
                                event_kind, payload_byte, message_last, message_type));
      end else begin
        want = pending_events.pop_front();
        if (event_kind !== want.kind || payload_byte !== want.data ||
            message_last !== want.last || message_type !== want.mtype)
          note_mismatch($sformatf({"event mismatch: expected kind %0d byte %02h last %0b ",
                                   "type %0d, got kind %0d byte %02h last %0b type %0d"},
                                  want.kind, want.data, want.last, want.mtype, event_kind,
                                  payload_byte, message_last, message_type));
      end
    end
  end

  // Receiver back-pressure: short stalls mostly, a few long, some long clean runs
  initial begin
    int unsigned run, hold;
    wait (!rst);
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150) : $urandom_range(0, 6);
      hold = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(8, 40);
      repeat (1 + run) @(posedge clk);
      out_stall <= 1'b1;
      repeat (hold) @(posedge clk);
      out_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------- drivers

  // Return at the accepting edge with valid still high; the caller drives next.
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap, r;
    r = $urandom_range(0, 99);
    if (burst || r < 55) gap = 0;
    else if (r < 92) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 40);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    deframe_byte(b);
    bytes_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    // header and key bytes may still be in flight with nothing expected
    repeat (6) @(posedge clk);
  endtask

  task automatic configure(input logic [31:0] limit, input logic client);
    cfg_we <= 1'b1;
    cfg_index <= CFG_MAX_MSG;
    cfg_data <= limit;
    @(posedge clk);
    cfg_index <= CFG_CLIENT;
    cfg_data <= {31'd0, client};
    @(posedge clk);
    cfg_we <= 1'b0;
    max_bytes = limit;
    client_mode = client;
  endtask

  // form: 0 seven-bit length, 1 sixteen-bit extended, 2 sixty-four-bit extended
  task automatic send_frame(input logic fin, input logic [3:0] op, input logic masked,
                            input int unsigned len, input int unsigned form);
    logic [31:0] mask_word;
    mask_word = $urandom;
    send_byte({fin, 3'($urandom_range(0, 7)), op});
    if (op == OP_PING || op == OP_PONG || op == OP_CLOSE) begin
      send_byte(8'($urandom));
      if (op == OP_CLOSE) msg_open = 1'b0;
    end else begin
      msg_open = !fin;
      if (form == 0) begin
        send_byte({masked, 7'(len)});
      end else if (form == 1) begin
        send_byte({masked, LEN16_CODE});
        send_byte(8'(len >> 8));
        send_byte(8'(len));
      end else begin
        send_byte({masked, LEN64_CODE});
        repeat (4) send_byte(8'h00);
        for (int i = 3; i >= 0; i--) send_byte(8'(len >> (8 * i)));
      end
      if (masked)
        for (int i = 3; i >= 0; i--) send_byte(mask_word[8 * i +: 8]);
      repeat (len) send_byte(8'($urandom));
    end
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_default_server();
    send_frame(1'b1, OP_TEXT, 1'b1, 3, 0);
    send_frame(1'b1, OP_BIN, 1'b1, 0, 0);
    send_frame(1'b1, OP_PING, 1'b1, 0, 0);
    send_frame(1'b0, OP_PONG, 1'b0, 0, 0);
    send_frame(1'b1, OP_CLOSE, 1'b1, 0, 0);
    wait_idle();
  endtask

  task automatic test_client_fragments();
    // unmasked final frame carrying both byte extremes
    send_byte({1'b1, 3'b000, OP_BIN});
    send_byte({1'b0, 7'd2});
    send_byte(8'h00);
    send_byte(8'hFF);
    send_frame(1'b0, OP_TEXT, 1'b1, 2, 1);
    send_frame(1'b0, OP_CONT, 1'b0, 0, 0);
    send_frame(1'b1, OP_PING, 1'b0, 0, 0);
    send_frame(1'b0, OP_BIN, 1'b1, 1, 0);
    send_frame(1'b1, OP_CONT, 1'b1, 2, 2);
    // continuation with no message open, then a message cut by close
    send_frame(1'b1, OP_CONT, 1'b0, 1, 0);
    send_frame(1'b0, OP_TEXT, 1'b0, 1, 0);
    send_frame(1'b1, OP_CLOSE, 1'b0, 0, 0);
    send_frame(1'b1, OP_CONT, 1'b1, 1, 0);
    wait_idle();
  endtask

  task automatic test_length_limits();
    configure(32'd10, 1'b0);
    send_frame(1'b0, OP_TEXT, 1'b1, 4, 0);
    send_frame(1'b1, OP_CONT, 1'b1, 5, 0);
    wait_idle();
    configure(32'd1, 1'b0);
    send_frame(1'b1, OP_BIN, 1'b1, 0, 0);
    wait_idle();
  endtask

  task automatic test_random_traffic();
    int unsigned start, r, len, form;
    logic [3:0] op;
    logic fin, masked;
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: configure(32'hFFFF_FFFF, 1'b1);
        1: configure(MAX_MSG_RESET, 1'b0);
        2: configure($urandom_range(20, 200), 1'b1);
        default: configure($urandom_range(2, 60), 1'b0);
      endcase
      start = bytes_sent;
      while (bytes_sent - start < 60) begin
        burst = ($urandom_range(0, 3) == 0);
        r = $urandom_range(0, 99);
        if (r < 7) begin
          send_frame(1'($urandom), OP_PING, 1'($urandom), 0, 0);
        end else if (r < 11) begin
          send_frame(1'($urandom), OP_PONG, 1'($urandom), 0, 0);
        end else if (r < 14 || msg_len >= max_bytes) begin
          send_frame(1'($urandom), OP_CLOSE, 1'($urandom), 0, 0);
        end else begin
          if (msg_open ? ($urandom_range(0, 9) < 8) : ($urandom_range(0, 9) == 0))
            op = OP_CONT;
          else
            op = $urandom_range(0, 1) ? OP_TEXT : OP_BIN;
          fin = ($urandom_range(0, 9) < 4);
          masked = client_mode ? 1'($urandom) : 1'b1;
          form = 0;
          r = $urandom_range(0, 99);
          if (r < 40) len = $urandom_range(0, 8);
          else if (r < 80) len = $urandom_range(9, 40);
          else if (r < 92) len = $urandom_range(41, 125);
          else if (r < 97) begin
            form = 1;
            len = $urandom_range(0, 300);
          end else begin
            form = 2;
            len = $urandom_range(0, 40);
          end
          // stay under the message limit
          if (len >= max_bytes - msg_len) len = max_bytes - msg_len - 1;
          send_frame(fin, op, masked, len, form);
        end
      end
      burst = 1'b0;
      wait_idle();
    end
  endtask

  task automatic test_error_halt();
    int unsigned pick;
    logic [3:0] bad_op;
    pick = $urandom_range(0, 3);
    case (pick)
      0: begin
        bad_op = $urandom_range(0, 1) ? 4'($urandom_range(OP_BIN + 1, OP_CLOSE - 1))
                                      : 4'($urandom_range(OP_PONG + 1, 4'hF));
        send_byte({1'b1, 3'b000, bad_op});
        send_byte(8'($urandom));
      end
      1: begin
        configure(MAX_MSG_RESET, 1'b0);
        send_byte({1'b1, 3'b000, OP_TEXT});
        send_byte({1'b0, 7'($urandom_range(0, 125))});
      end
      2: begin
        configure(MAX_MSG_RESET, 1'b1);
        send_byte({1'b1, 3'b000, OP_BIN});
        send_byte({1'b0, LEN64_CODE});
        send_byte(8'($urandom_range(1, 255)));
        repeat (7) send_byte(8'($urandom));
      end
      default: begin
        // lower the limit below a message already in progress
        configure(32'hFFFF_FFFF, 1'b1);
        send_frame(1'b0, OP_TEXT, 1'b1, 6, 0);
        wait_idle();
        configure(32'd4, 1'b1);
        send_frame(1'b1, OP_CONT, 1'b1, 2, 0);
      end
    endcase
    // halted: everything after the error is dropped
    repeat (12) send_byte(8'($urandom));
    wait_idle();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_default_server();
    configure(32'hFFFF_FFFF, 1'b1);
    test_client_fragments();
    test_length_limits();
    test_random_traffic();
    test_error_halt();
    if (pending_events.size() != 0) begin
      $display("%0d expected events never arrived", pending_events.size());
      mismatches += pending_events.size();
    end
    $display({"%0d bytes sent; events checked: %0d payload, %0d message end, ",
              "%0d close, %0d pong, %0d error"},
             bytes_sent, kind_count[EV_BYTE], kind_count[EV_END], kind_count[EV_CLOSE],
             kind_count[EV_PONG], kind_count[EV_ERROR]);
    $display("limits 1 to 4294967295, server and client modes, halt after error; %0d mismatches",
             mismatches);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
